FILE: rtl/modbus_rtu_response_checker_defines.svh
// assertion macros for the checker module
`ifndef MODBUS_RTU_RESPONSE_CHECKER_DEFINES_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_DEFINES_SVH

// property checked outside reset
`define MRC_CHECK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("modbus response checker: property failed");

// property checked at every edge, reset included
`define MRC_CHECK_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("modbus response checker: property failed at reset");

`endif

FILE: rtl/mrc_pkg.sv
package mrc_pkg;

   // sizing
   localparam int MAX_WORDS_DEFAULT = 16;
   localparam int CSR_INDEX_W       = 1;
   localparam int CSR_DATA_W        = 8;
   localparam logic [8:0] POS_MAX   = 9'd511;

   // byte positions of the header fields
   localparam logic [8:0] POS_ADDRESS   = 9'd0;
   localparam logic [8:0] POS_FUNCTION  = 9'd1;
   localparam logic [8:0] POS_EXCEPTION = 9'd2;
   localparam logic [8:0] POS_MIN_WORDS = 9'd5;

   // crc-16 constants
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // function and exception codes
   localparam logic [6:0] FUNC_READ        = 7'h03;
   localparam logic [7:0] EXC_FLAG         = 8'h80;
   localparam logic [7:0] EXC_NACK         = 8'h07;
   localparam logic [7:0] EXC_BUSY         = 8'h06;
   localparam logic [7:0] EXC_UNSUPPORTED  = 8'h01;
   localparam logic [7:0] EXC_ILLEGAL_DATA = 8'h03;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_NODE_ADDRESS      = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_FUNCTION = 1'b1;

   // status codes
   localparam logic [3:0] STATUS_OK           = 4'd0;
   localparam logic [3:0] STATUS_CRC          = 4'd1;
   localparam logic [3:0] STATUS_ADDRESS      = 4'd2;
   localparam logic [3:0] STATUS_NACK         = 4'd3;
   localparam logic [3:0] STATUS_BUSY         = 4'd4;
   localparam logic [3:0] STATUS_UNSUPPORTED  = 4'd5;
   localparam logic [3:0] STATUS_ILLEGAL_DATA = 4'd6;
   localparam logic [3:0] STATUS_UNKNOWN      = 4'd7;
   localparam logic [3:0] STATUS_FUNCTION     = 4'd8;

   // result kinds
   localparam logic KIND_WORD   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       end_of_frame;
   } req_type;

   typedef struct packed {
      logic        item_kind;
      logic [15:0] word_value;
      logic [3:0]  word_index;
      logic [3:0]  status_code;
      logic        last_result;
   } rsp_type;

   // header and crc state handed from the parser to the emitter
   typedef struct packed {
      logic [15:0] crc;
      logic [8:0]  position;
      logic [7:0]  address;
      logic [7:0]  func;
      logic [7:0]  exception;
   } frame_type;

   typedef enum logic [2:0] {
      EM_COLLECT,
      EM_VERDICT,
      EM_READ,
      EM_WORD,
      EM_STATUS
   } emit_state_type;

   // one byte through the reflected crc-16, lsb first
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc_value,
                                             input logic [7:0] data);
      logic [15:0] acc;
      acc = crc_value;
      for (int i = 0; i < 8; i++) begin
         if (acc[0] ^ data[i]) begin
            acc = (acc >> 1) ^ CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      return acc;
   endfunction

endpackage

FILE: rtl/mrc_word_ram.sv
module mrc_word_ram #(
   parameter int DEPTH = mrc_pkg::MAX_WORDS_DEFAULT,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              write_enable,
   input  logic [ADDR_W-1:0] write_address,
   input  logic [15:0]       write_data,
   input  logic              read_enable,
   input  logic [ADDR_W-1:0] read_address,
   output logic [15:0]       read_data
);

   logic [15:0] mem_ff [DEPTH];
   logic [15:0] read_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
   end

   // registered read port, holds between reads
   always_ff @(posedge clock) begin
      if (read_enable) begin
         read_data_ff <= mem_ff[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

FILE: rtl/mrc_frame_parser.sv
module mrc_frame_parser #(
   parameter int MAX_WORDS = mrc_pkg::MAX_WORDS_DEFAULT,
   localparam int ADDR_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  mrc_pkg::req_type    req,
   input  logic                clear,
   output mrc_pkg::frame_type  frame,
   output logic                ram_write_enable,
   output logic [ADDR_W-1:0]   ram_write_address,
   output logic [15:0]         ram_write_data
);

   localparam logic [8:0] MAX_WORDS_9 = 9'(MAX_WORDS);

   logic [15:0] crc_ff, crc_in;
   logic [8:0]  pos_ff, pos_in;
   logic [7:0]  address_ff, address_in;
   logic [7:0]  func_ff, func_in;
   logic [7:0]  exception_ff, exception_in;
   logic [7:0]  pending_ff, pending_in;
   logic [7:0]  word_slot;

   // slot of a low byte: (position - 4) / 2
   assign word_slot = pos_ff[8:1] - 8'd2;

   // per-byte update of crc, header capture and word assembly
   always_comb begin
      crc_in           = crc_ff;
      pos_in           = pos_ff;
      address_in       = address_ff;
      func_in          = func_ff;
      exception_in     = exception_ff;
      pending_in       = pending_ff;
      ram_write_enable = 1'b0;
      ram_write_address = word_slot[ADDR_W-1:0];
      ram_write_data   = {pending_ff, req.rx_byte};
      if (clear) begin
         crc_in       = mrc_pkg::CRC_INIT;
         pos_in       = 9'd0;
         address_in   = 8'd0;
         func_in      = 8'd0;
         exception_in = 8'd0;
      end else if (accept) begin
         crc_in = mrc_pkg::crc16_byte(crc_ff, req.rx_byte);
         pos_in = (pos_ff != mrc_pkg::POS_MAX) ? pos_ff + 9'd1 : pos_ff;
         priority if (pos_ff == mrc_pkg::POS_ADDRESS) begin
            address_in = req.rx_byte;
         end else if (pos_ff == mrc_pkg::POS_FUNCTION) begin
            func_in = req.rx_byte;
         end else if (pos_ff == mrc_pkg::POS_EXCEPTION) begin
            exception_in = req.rx_byte;
         end else if (pos_ff[0]) begin
            pending_in = req.rx_byte;
         end else begin
            ram_write_enable = ({1'b0, word_slot} < MAX_WORDS_9);
         end
      end
   end

   // frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= mrc_pkg::CRC_INIT;
         pos_ff       <= 9'd0;
         address_ff   <= 8'd0;
         func_ff      <= 8'd0;
         exception_ff <= 8'd0;
         pending_ff   <= 8'd0;
      end else begin
         crc_ff       <= crc_in;
         pos_ff       <= pos_in;
         address_ff   <= address_in;
         func_ff      <= func_in;
         exception_ff <= exception_in;
         pending_ff   <= pending_in;
      end
   end

   assign frame.crc       = crc_ff;
   assign frame.position  = pos_ff;
   assign frame.address   = address_ff;
   assign frame.func      = func_ff;
   assign frame.exception = exception_ff;

endmodule

FILE: rtl/mrc_emitter.sv
module mrc_emitter #(
   parameter int MAX_WORDS = mrc_pkg::MAX_WORDS_DEFAULT,
   localparam int ADDR_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               eof_accept,
   input  mrc_pkg::frame_type frame,
   input  logic [7:0]         node_address,
   input  logic [6:0]         expected_function,
   output logic               collect,
   output logic               clear,
   output logic               ram_read_enable,
   output logic [ADDR_W-1:0]  ram_read_address,
   input  logic [15:0]        ram_read_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mrc_pkg::rsp_type   rsp_data
);

   localparam int CNT_W = $clog2(MAX_WORDS + 1);
   localparam logic [7:0] MAX_WORDS_8 = 8'(MAX_WORDS);

   mrc_pkg::emit_state_type state_ff, state_in;
   logic [3:0]       status_ff, status_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             rsp_valid_ff, rsp_valid_in;
   mrc_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             out_free;
   logic [3:0]       verdict;
   logic [7:0]       pairs;
   logic [7:0]       exc_func;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign exc_func = {1'b0, expected_function} | mrc_pkg::EXC_FLAG;

   // verdict from the stored header and crc residue
   always_comb begin
      priority if (frame.crc != 16'd0) begin
         verdict = mrc_pkg::STATUS_CRC;
      end else if (frame.address != node_address) begin
         verdict = mrc_pkg::STATUS_ADDRESS;
      end else if (frame.func == exc_func) begin
         priority if (frame.exception == mrc_pkg::EXC_NACK) begin
            verdict = mrc_pkg::STATUS_NACK;
         end else if (frame.exception == mrc_pkg::EXC_BUSY) begin
            verdict = mrc_pkg::STATUS_BUSY;
         end else if (frame.exception == mrc_pkg::EXC_UNSUPPORTED) begin
            verdict = mrc_pkg::STATUS_UNSUPPORTED;
         end else if (frame.exception == mrc_pkg::EXC_ILLEGAL_DATA) begin
            verdict = mrc_pkg::STATUS_ILLEGAL_DATA;
         end else begin
            verdict = mrc_pkg::STATUS_UNKNOWN;
         end
      end else if (frame.func != {1'b0, expected_function}) begin
         verdict = mrc_pkg::STATUS_FUNCTION;
      end else begin
         verdict = mrc_pkg::STATUS_OK;
      end
   end

   // whole byte pairs between the header and the crc
   assign pairs = (frame.position >= mrc_pkg::POS_MIN_WORDS) ?
                  8'((frame.position - mrc_pkg::POS_MIN_WORDS) >> 1) : 8'd0;

   // next state and outputs
   always_comb begin
      state_in         = state_ff;
      status_in        = status_ff;
      count_in         = count_ff;
      k_in             = k_ff;
      collect          = 1'b0;
      clear            = 1'b0;
      ram_read_enable  = 1'b0;
      ram_read_address = k_ff[ADDR_W-1:0];
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_data_in      = rsp_data_ff;
      unique case (state_ff)
         mrc_pkg::EM_COLLECT: begin
            collect = 1'b1;
            if (eof_accept) begin
               state_in = mrc_pkg::EM_VERDICT;
            end
         end
         mrc_pkg::EM_VERDICT: begin
            clear     = 1'b1;
            status_in = verdict;
            k_in      = '0;
            if (verdict == mrc_pkg::STATUS_OK &&
                expected_function == mrc_pkg::FUNC_READ) begin
               count_in = (pairs > MAX_WORDS_8) ? CNT_W'(MAX_WORDS) : CNT_W'(pairs);
            end else begin
               count_in = '0;
            end
            state_in = (count_in != '0) ? mrc_pkg::EM_READ : mrc_pkg::EM_STATUS;
         end
         mrc_pkg::EM_READ: begin
            ram_read_enable = 1'b1;
            state_in        = mrc_pkg::EM_WORD;
         end
         mrc_pkg::EM_WORD: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.item_kind   = mrc_pkg::KIND_WORD;
               rsp_data_in.word_value  = ram_read_data;
               rsp_data_in.word_index  = 4'(k_ff);
               rsp_data_in.status_code = mrc_pkg::STATUS_OK;
               rsp_data_in.last_result = 1'b0;
               k_in                    = k_ff + CNT_W'(1);
               state_in = (k_in == count_ff) ? mrc_pkg::EM_STATUS : mrc_pkg::EM_READ;
            end
         end
         mrc_pkg::EM_STATUS: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.item_kind   = mrc_pkg::KIND_STATUS;
               rsp_data_in.word_value  = 16'd0;
               rsp_data_in.word_index  = 4'd0;
               rsp_data_in.status_code = status_ff;
               rsp_data_in.last_result = 1'b1;
               state_in                = mrc_pkg::EM_COLLECT;
            end
         end
         default: begin
            state_in = mrc_pkg::EM_COLLECT;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mrc_pkg::EM_COLLECT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      count_ff    <= count_in;
      k_ff        <= k_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/modbus_rtu_response_checker.sv
// channel   ports                               moves
// request   req_valid / req_ready / req_data    one frame byte and end mark
// response  rsp_valid / rsp_ready / rsp_data    data word or closing status
// csr       csr_write_enable / csr_index / ...  register write, no wait
//
// a byte is taken whenever req_valid is high while the frame is collected
// after the end byte: a verdict state, then per data word a word memory read
// and a word output, then the status; these outputs wait while rsp_ready
// is low; req_ready is low from the end byte until the status is registered
// synchronous reset restores control, configuration and parser registers
// and crc state; emitter payload registers and word memory are left as is
module modbus_rtu_response_checker #(
   parameter int MAX_WORDS = mrc_pkg::MAX_WORDS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  mrc_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output mrc_pkg::rsp_type                 rsp_data,
   input  logic                             csr_write_enable,
   input  logic [mrc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mrc_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   localparam int ADDR_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

   logic [7:0]         node_address_ff;
   logic [6:0]         expected_function_ff;
   logic               req_accept;
   logic               collect;
   logic               clear;
   mrc_pkg::frame_type frame;
   logic               ram_write_enable;
   logic [ADDR_W-1:0]  ram_write_address;
   logic [15:0]        ram_write_data;
   logic               ram_read_enable;
   logic [ADDR_W-1:0]  ram_read_address;
   logic [15:0]        ram_read_data;

   assign req_ready  = collect;
   assign req_accept = req_valid && req_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         node_address_ff      <= 8'd1;
         expected_function_ff <= mrc_pkg::FUNC_READ;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            mrc_pkg::CSR_NODE_ADDRESS: begin
               node_address_ff <= csr_write_data;
            end
            mrc_pkg::CSR_EXPECTED_FUNCTION: begin
               expected_function_ff <= csr_write_data[6:0];
            end
            default: begin
            end
         endcase
      end
   end

   // byte intake, crc and word writes
   mrc_frame_parser #(
      .MAX_WORDS (MAX_WORDS)
   ) u_parser (
      .clock             (clock),
      .reset             (reset),
      .accept            (req_accept),
      .req               (req_data),
      .clear             (clear),
      .frame             (frame),
      .ram_write_enable  (ram_write_enable),
      .ram_write_address (ram_write_address),
      .ram_write_data    (ram_write_data)
   );

   // word store; reads only happen while no bytes are taken
   mrc_word_ram #(
      .DEPTH (MAX_WORDS)
   ) u_ram (
      .clock         (clock),
      .write_enable  (ram_write_enable),
      .write_address (ram_write_address),
      .write_data    (ram_write_data),
      .read_enable   (ram_read_enable),
      .read_address  (ram_read_address),
      .read_data     (ram_read_data)
   );

   // verdict and result sequencing
   mrc_emitter #(
      .MAX_WORDS (MAX_WORDS)
   ) u_emitter (
      .clock             (clock),
      .reset             (reset),
      .eof_accept        (req_accept && req_data.end_of_frame),
      .frame             (frame),
      .node_address      (node_address_ff),
      .expected_function (expected_function_ff),
      .collect           (collect),
      .clear             (clear),
      .ram_read_enable   (ram_read_enable),
      .ram_read_address  (ram_read_address),
      .ram_read_data     (ram_read_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data          (rsp_data)
   );

endmodule

FILE: rtl/mrc_checker.sv
`include "modbus_rtu_response_checker_defines.svh"

module mrc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input mrc_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input mrc_pkg::rsp_type rsp_data
);

   // a stalled response holds
   `MRC_CHECK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))

   // a status item closes the frame and carries no word
   `MRC_CHECK(a_status_shape, rsp_valid && rsp_data.item_kind |-> rsp_data.last_result && rsp_data.word_value == 16'd0 && rsp_data.word_index == 4'd0)

   // a word item never closes the frame
   `MRC_CHECK(a_word_shape, rsp_valid && !rsp_data.item_kind |-> !rsp_data.last_result && rsp_data.status_code == mrc_pkg::STATUS_OK)

   // the end byte blocks intake for the verdict cycle
   `MRC_CHECK(a_eof_blocks, req_valid && req_ready && req_data.end_of_frame |=> !req_ready)

   // nothing is offered straight out of reset
   `MRC_CHECK_ALWAYS(a_reset_idle, reset |=> !rsp_valid)

endmodule

bind modbus_rtu_response_checker mrc_checker u_mrc_checker (.*);
